// ===== sv/rsc_pkg.sv =====
package rsc_pkg;

    // Default sizing
    localparam int ACC_WIDTH_DEF      = 32;
    localparam int MAX_OUT_DIGITS_DEF = 32;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int RADIX_W  = 5;
    localparam int DIGIT_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RADIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RADIX = 2'd1;

    // Register reset values
    localparam logic [RADIX_W-1:0] INPUT_RADIX_RST  = 5'd10;
    localparam logic [RADIX_W-1:0] OUTPUT_RADIX_RST = 5'd2;

    // Output radix clamp limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_F = 8'h46;
    localparam logic [CHAR_W-1:0] TEN    = 8'd10;

    // ASCII character to digit value; anything not 0-9 or A-F is zero
    function automatic logic [DIGIT_W-1:0] char_value(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (ch inside {[CHAR_0:CHAR_9]})
        begin
            d = ch - CHAR_0;
        end
        else if (ch inside {[CHAR_A:CHAR_F]})
        begin
            d = ch - CHAR_A + TEN;
        end
        return d[DIGIT_W-1:0];
    endfunction

    // Digit value to uppercase ASCII
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (dx < TEN)
        begin
            return dx + CHAR_0;
        end
        return dx + (CHAR_A - TEN);
    endfunction

endpackage

// ===== sv/rsc_ram.sv =====
module rsc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rsc_divider.sv =====
module rsc_divider
    import rsc_pkg::*;
#(
    parameter int DATA_W = ACC_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DATA_W-1:0]  dividend,
    input  logic [RADIX_W-1:0] divisor,
    output logic               done,
    output logic [DATA_W-1:0]  quotient,
    output logic [DIGIT_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DATA_W-1:0]  quot_reg, quot_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;

    logic [RADIX_W-1:0] trial;
    logic [RADIX_W-1:0] diff;
    logic               fits;

    // Restoring step: one quotient bit per cycle, remainder stays below divisor
    always_comb
    begin
        trial = {rem_reg, quot_reg[DATA_W-1]};
        fits  = (trial >= divisor);
        diff  = trial - divisor;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DATA_W-2:0], fits};
            rem_next  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/radix_string_converter.sv =====
// Channel | Direction | Handshake           | Word
// --------+-----------+---------------------+------------------------------------
// in      | input     | in_valid / in_ready | digit_char[7:0], last_digit
// out     | output    | out_valid/out_ready | out_char[7:0], last_out
// cfg     | input     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[4:0]
//
// A character that is not last folds into the accumulator when it is accepted.
// The last character starts a conversion: each output digit comes from the
// shared bit-serial divider, then each digit is read back from the digit RAM
// (S_READ, then S_LOAD), waiting on any output stall. in_ready is low
// from the last character until the final digit sits in the output register.
// Reset (rst_n, async, active low) clears the accumulator and sets the radixes
// to 10 in, 2 out; the digit RAM needs no clearing. cfg_ready is always high.
module radix_string_converter
    import rsc_pkg::*;
#(
    parameter int ACC_WIDTH      = ACC_WIDTH_DEF,
    parameter int MAX_OUT_DIGITS = MAX_OUT_DIGITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CHAR_W-1:0]    digit_char,
    input  logic                 last_digit,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAR_W-1:0]    out_char,
    output logic                 last_out,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RADIX_W-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(MAX_OUT_DIGITS);
    localparam int CNT_W  = $clog2(MAX_OUT_DIGITS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [RADIX_W-1:0]   in_radix_reg, in_radix_next;
    logic [RADIX_W-1:0]   out_radix_reg, out_radix_next;
    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic [ACC_WIDTH-1:0] val_reg, val_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 last_out_reg, last_out_next;

    logic [ACC_WIDTH-1:0] folded;
    logic [RADIX_W-1:0]   radix;
    logic                 in_fire;
    logic                 load;

    logic                 div_start;
    logic                 div_done;
    logic [ACC_WIDTH-1:0] div_quot;
    logic [DIGIT_W-1:0]   div_rem;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [DIGIT_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [DIGIT_W-1:0]   ram_rdata;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    // Fold: acc * input radix + digit, wrapping at ACC_WIDTH
    assign folded = acc_reg * {{(ACC_WIDTH-RADIX_W){1'b0}}, in_radix_reg}
                  + {{(ACC_WIDTH-DIGIT_W){1'b0}}, char_value(digit_char)};

    // Output radix clamped to 2..16
    always_comb
    begin
        radix = out_radix_reg;
        if (out_radix_reg < RADIX_MIN)
        begin
            radix = RADIX_MIN;
        end
        else if (out_radix_reg > RADIX_MAX)
        begin
            radix = RADIX_MAX;
        end
    end

    // Output register is free when empty or being drained this cycle
    assign load = (state_reg == S_LOAD) && (!out_valid_reg || out_ready);

    // Configuration writes
    always_comb
    begin
        in_radix_next  = in_radix_reg;
        out_radix_next = out_radix_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INPUT_RADIX:  in_radix_next  = cfg_data;
                CFG_OUTPUT_RADIX: out_radix_next = cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        div_start      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[ADDR_W-1:0];
        ram_wdata      = div_rem;
        ram_re         = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        last_out_next  = last_out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (last_digit)
                    begin
                        acc_next   = '0;
                        val_next   = folded;
                        cnt_next   = '0;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        acc_next = folded;
                    end
                end
            end
            S_CHECK:
            begin
                if (val_reg == '0 && cnt_reg == '0)
                begin
                    // zero value: a single "0" digit
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = '0;
                    cnt_next   = CNT_W'(1);
                    idx_next   = '0;
                    state_next = S_READ;
                end
                else if (val_reg == '0 || cnt_reg == CNT_W'(MAX_OUT_DIGITS))
                begin
                    idx_next   = ADDR_W'(cnt_reg - 1'b1);
                    state_next = S_READ;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    ram_we     = 1'b1;
                    val_next   = div_quot;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_to_char(ram_rdata);
                    last_out_next  = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_radix_reg  <= INPUT_RADIX_RST;
            out_radix_reg <= OUTPUT_RADIX_RST;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_radix_reg  <= in_radix_next;
            out_radix_reg <= out_radix_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        out_char_reg <= out_char_next;
        last_out_reg <= last_out_next;
    end

    // Shared divider by the output radix
    rsc_divider #(
        .DATA_W (ACC_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (val_reg),
        .divisor   (radix),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Remainder store, least significant digit at address 0
    rsc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_OUT_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_out  = last_out_reg;

    // Divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");

    // Digit count never passes the store depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_OUT_DIGITS))
        else $error("digit count past store depth");

    // Readback only touches digits that were produced
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (cnt_reg != '0 && CNT_W'(idx_reg) < cnt_reg))
        else $error("digit read outside produced range");

    // Loading the least significant digit flags it and frees the input
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (load && idx_reg == '0) |=> (last_out && out_valid && in_ready))
        else $error("final digit not flagged");

endmodule
